/* design/mppt_po_pkg.sv */
package mppt_po_pkg;

	// serial multiplier geometry
	localparam int unsigned MUL_A_W   = 21;
	localparam int unsigned MUL_B_W   = 16;
	localparam int unsigned MUL_P_W   = 32;
	localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);

	// limiter constants, multiplier operand left-aligned, msb first
	localparam int unsigned VOUT_GAIN     = 21;
	localparam int unsigned VOUT_GAIN_N   = 5;
	localparam int unsigned VOUT_THRESH   = 3360;
	localparam int unsigned VOUT_THRESH_N = 12;
	localparam logic [MUL_B_W-1:0] B_VOUT_GAIN =
		MUL_B_W'(VOUT_GAIN << (MUL_B_W - VOUT_GAIN_N));
	localparam logic [MUL_B_W-1:0] B_VOUT_THRESH =
		MUL_B_W'(VOUT_THRESH << (MUL_B_W - VOUT_THRESH_N));

	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned LIM_CNT_W = 9;

	// register indexes
	localparam logic [1:0] REG_DUTY_MAX  = 2'd0;
	localparam logic [1:0] REG_DUTY_MIN  = 2'd1;
	localparam logic [1:0] REG_DUTY_STEP = 2'd2;
	localparam logic [1:0] REG_VOUT_MAX  = 2'd3;

	typedef struct packed {
		logic                 start;
		logic [MUL_CNT_W-1:0] nbits;
	} mul_cmd_t;

endpackage

/* design/mppt_po_mul.sv */
module mppt_po_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mppt_po_pkg::mul_cmd_t               cmd,
	input  logic [mppt_po_pkg::MUL_A_W-1:0]     a,
	input  logic [mppt_po_pkg::MUL_B_W-1:0]     b,
	output logic [mppt_po_pkg::MUL_P_W-1:0]     prod,
	output logic                                done
);
	import mppt_po_pkg::*;

	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// msb-first shift and add, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= {b_q[MUL_B_W-2:0], 1'b0};
			acc_q <= {acc_q[MUL_P_W-2:0], 1'b0}
				+ (b_q[MUL_B_W-1] ? {{(MUL_P_W-MUL_A_W){1'b0}}, a_q} : '0);
		end
	end

	assign prod = acc_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("multiplier started while busy");
`endif

endmodule

/* design/mppt_perturb_observe_step_core.sv */
// channel   dir  handshake             payload
// in        in   in_valid / in_stall   voltage_avg[15:0], current_avg[15:0]
// out       out  out_valid / out_stall duty[7:0], power[31:0], direction
// cfg       in   cfg_wen               cfg_idx[1:0], cfg_data[15:0]
//
// one beat at a time; the run time of a beat is set by the bit-serial multiplier
// (one bit a cycle) and the limiter loop that reuses it for every duty candidate
// arst_n clears config to its defaults and duty, direction, last power to zero
// in_stall is high from acceptance until the result is loaded
// a result held by out_stall blocks only the final load, not the next accept
module mppt_perturb_observe_step_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] voltage_avg,
	input  logic [15:0] current_avg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  duty,
	output logic [31:0] power,
	output logic        direction
);
	import mppt_po_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PW_GO = 4'd1;
	localparam logic [3:0] ST_PW_WT = 4'd2;
	localparam logic [3:0] ST_K_GO  = 4'd3;
	localparam logic [3:0] ST_K_WT  = 4'd4;
	localparam logic [3:0] ST_R_GO  = 4'd5;
	localparam logic [3:0] ST_R_WT  = 4'd6;
	localparam logic [3:0] ST_DIR   = 4'd7;
	localparam logic [3:0] ST_LIM   = 4'd8;
	localparam logic [3:0] ST_L_WT  = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0] state_q;

	// configuration
	logic [DUTY_W-1:0] duty_max_q;
	logic [DUTY_W-1:0] duty_min_q;
	logic [DUTY_W-1:0] duty_step_q;
	logic [15:0]       vout_max_q;

	// tracker state
	logic [DUTY_W-1:0]  duty_q;
	logic               dir_q;
	logic [MUL_P_W-1:0] prev_q;

	// per-beat working values
	logic [15:0]          v_q;
	logic [15:0]          c_q;
	logic [MUL_P_W-1:0]   p_q;
	logic [MUL_A_W-1:0]   k_q;     // vout_max*21 + voltage
	logic [27:0]          rhs_q;   // vout_max*3360
	logic [LIM_CNT_W-1:0] lim_cnt_q;

	// output register
	logic               out_valid_q;
	logic [DUTY_W-1:0]  duty_out_q;
	logic [MUL_P_W-1:0] power_out_q;
	logic               dir_out_q;

	mul_cmd_t           mul_cmd;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_prod;
	logic               mul_done;

	logic in_acc;
	logic out_acc;
	logic flip;
	logic dir_n;
	logic in_band;
	logic lim_go;
	logic out_free;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// reversal on leaving the duty window or on a drop in power
	assign flip  = (duty_q > duty_max_q) || (duty_q < duty_min_q) || (p_q < prev_q);
	assign dir_n = dir_q ^ flip;

	// limiter only runs strictly inside the window and within its bound
	assign in_band = (duty_q > duty_min_q) && (duty_q < duty_max_q);
	assign lim_go  = in_band && !lim_cnt_q[LIM_CNT_W-1];

	// operand selection for the shared multiplier
	always_comb begin
		mul_cmd.start = 1'b0;
		mul_cmd.nbits = MUL_CNT_W'(MUL_B_W);
		mul_a         = {{(MUL_A_W-16){1'b0}}, v_q};
		mul_b         = c_q;
		unique case (state_q)
			ST_PW_GO: begin
				mul_cmd.start = 1'b1;
			end
			ST_K_GO: begin
				mul_cmd.start = 1'b1;
				mul_cmd.nbits = MUL_CNT_W'(VOUT_GAIN_N);
				mul_a         = {{(MUL_A_W-16){1'b0}}, vout_max_q};
				mul_b         = B_VOUT_GAIN;
			end
			ST_R_GO: begin
				mul_cmd.start = 1'b1;
				mul_cmd.nbits = MUL_CNT_W'(VOUT_THRESH_N);
				mul_a         = {{(MUL_A_W-16){1'b0}}, vout_max_q};
				mul_b         = B_VOUT_THRESH;
			end
			ST_LIM: begin
				// duty left-aligned so eight bits suffice
				mul_cmd.start = lim_go;
				mul_cmd.nbits = MUL_CNT_W'(DUTY_W);
				mul_a         = k_q;
				mul_b         = {duty_q, {(MUL_B_W-DUTY_W){1'b0}}};
			end
			default: begin
			end
		endcase
	end

	mppt_po_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_max_q  <= DUTY_W'(150);
			duty_min_q  <= DUTY_W'(10);
			duty_step_q <= DUTY_W'(1);
			vout_max_q  <= 16'd60;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_DUTY_MAX:  duty_max_q  <= cfg_data[DUTY_W-1:0];
				REG_DUTY_MIN:  duty_min_q  <= cfg_data[DUTY_W-1:0];
				REG_DUTY_STEP: duty_step_q <= cfg_data[DUTY_W-1:0];
				REG_VOUT_MAX:  vout_max_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			duty_q      <= '0;
			dir_q       <= 1'b0;
			prev_q      <= '0;
			lim_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PW_GO;
					end
				end
				ST_PW_GO: state_q <= ST_PW_WT;
				ST_PW_WT: begin
					if (mul_done) begin
						state_q <= ST_K_GO;
					end
				end
				ST_K_GO: state_q <= ST_K_WT;
				ST_K_WT: begin
					if (mul_done) begin
						state_q <= ST_R_GO;
					end
				end
				ST_R_GO: state_q <= ST_R_WT;
				ST_R_WT: begin
					if (mul_done) begin
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					dir_q     <= dir_n;
					duty_q    <= dir_n ? duty_q + duty_step_q : duty_q - duty_step_q;
					prev_q    <= p_q;
					lim_cnt_q <= '0;
					state_q   <= ST_LIM;
				end
				ST_LIM: begin
					state_q <= lim_go ? ST_L_WT : ST_FIN;
				end
				ST_L_WT: begin
					if (mul_done) begin
						if (mul_prod >= {{(MUL_P_W-28){1'b0}}, rhs_q}) begin
							duty_q    <= duty_q - duty_step_q;
							lim_cnt_q <= lim_cnt_q + LIM_CNT_W'(1);
							state_q   <= ST_LIM;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q <= voltage_avg;
			c_q <= current_avg;
		end
		if (mul_done && state_q == ST_PW_WT) begin
			p_q <= mul_prod;
		end
		if (mul_done && state_q == ST_K_WT) begin
			k_q <= mul_prod[MUL_A_W-1:0] + {{(MUL_A_W-16){1'b0}}, v_q};
		end
		if (mul_done && state_q == ST_R_WT) begin
			rhs_q <= mul_prod[27:0];
		end
		if (state_q == ST_FIN && out_free) begin
			duty_out_q  <= duty_q;
			power_out_q <= p_q;
			dir_out_q   <= dir_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign duty      = duty_out_q;
	assign power     = power_out_q;
	assign direction = dir_out_q;

`ifndef SYNTHESIS
	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_PW_WT || state_q == ST_K_WT
			|| state_q == ST_R_WT || state_q == ST_L_WT))
		else $error("multiplier result with no step waiting for it");
	a_lim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lim_cnt_q[LIM_CNT_W-1] |-> (lim_cnt_q[LIM_CNT_W-2:0] == '0))
		else $error("limiter ran past its iteration bound");
	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_FIN))
		else $error("result loaded outside the final step");
`endif

endmodule
